[rtl/tftpc_pkg.sv]
// ----------------------------------------------------------------------------
// tftpc_pkg
// Shared types and constants of the TFTP client transfer engine: item and
// result layouts, opcode and action codes, phases and register indexes.
// ----------------------------------------------------------------------------
package tftpc_pkg;

  // Field widths
  localparam int OPCODE_W   = 2;
  localparam int PKT_LEN_W  = 10;
  localparam int KIND_W     = 16;
  localparam int BLOCK_W    = 16;
  localparam int ACTION_W   = 3;
  localparam int WAIT_W     = 20;
  localparam int TIMEOUT_W  = 16;
  localparam int RETRIES_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Protocol constants
  localparam int HDR_BYTES = 4;
  localparam logic [KIND_W-1:0] KIND_DATA = 16'd3;
  localparam logic [KIND_W-1:0] KIND_ACK  = 16'd4;

  // Register reset values
  localparam logic                 DIRECTION_RST = 1'b0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd100;
  localparam logic [RETRIES_W-1:0] RETRIES_RST   = 4'd5;

  // Result queue
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = 3;
  localparam int RES_CNT_W = 4;
  localparam int RES_MAX   = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START = 2'd0,
    OP_PKT   = 2'd1,
    OP_TICK  = 2'd2,
    OP_CHUNK = 2'd3
  } op_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQ   = 3'd0,
    ACT_ACK   = 3'd1,
    ACT_STORE = 3'd2,
    ACT_DATA  = 3'd3,
    ACT_NEED  = 3'd4,
    ACT_DONE  = 3'd5,
    ACT_FAIL  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_GET_WAIT  = 3'd1,
    PH_PUT_ACK0  = 3'd2,
    PH_PUT_CHUNK = 3'd3,
    PH_PUT_ACK   = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_RETRIES   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t                  opcode;
    logic [PKT_LEN_W-1:0] pkt_len;
    logic [KIND_W-1:0]    pkt_kind;
    logic [BLOCK_W-1:0]   pkt_block;
    logic [PKT_LEN_W-1:0] chunk_len;
  } in_item_t;

  typedef struct packed {
    action_t              action;
    logic [BLOCK_W-1:0]   block_no;
    logic [PKT_LEN_W-1:0] length;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic                 direction;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [RETRIES_W-1:0] max_retries;
  } cfg_t;

  // Results caused by one item, slot 0 first
  typedef struct packed {
    logic [1:0]         cnt;
    res_t [RES_MAX-1:0] res;
  } push_t;

endpackage

[rtl/tftpc_in_if.sv]
// ----------------------------------------------------------------------------
// tftpc_in_if
// Input item channel: event opcode with received packet and chunk fields.
// ----------------------------------------------------------------------------
interface tftpc_in_if import tftpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_t                  opcode;
  logic [PKT_LEN_W-1:0] pkt_len;
  logic [KIND_W-1:0]    pkt_kind;
  logic [BLOCK_W-1:0]   pkt_block;
  logic [PKT_LEN_W-1:0] chunk_len;

  modport source (output valid, opcode, pkt_len, pkt_kind, pkt_block, chunk_len,
                  input ready);
  modport sink (input valid, opcode, pkt_len, pkt_kind, pkt_block, chunk_len,
                output ready);
endinterface

[rtl/tftpc_out_if.sv]
// ----------------------------------------------------------------------------
// tftpc_out_if
// Result channel: action with block number, length and last marker.
// ----------------------------------------------------------------------------
interface tftpc_out_if import tftpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  action_t              action;
  logic [BLOCK_W-1:0]   block_no;
  logic [PKT_LEN_W-1:0] length;
  logic                 last;

  modport source (output valid, action, block_no, length, last, input ready);
  modport sink (input valid, action, block_no, length, last, output ready);
endinterface

[rtl/tftpc_cfg_if.sv]
// ----------------------------------------------------------------------------
// tftpc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tftpc_cfg_if import tftpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tftpc_fifo.sv]
// ----------------------------------------------------------------------------
// tftpc_fifo
// Result queue: takes up to three results per cycle, hands out one per
// transfer from its head.
// ----------------------------------------------------------------------------
module tftpc_fifo import tftpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  room,
  output logic  head_valid,
  output res_t  head
);

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wp_r;
  logic [RES_PTR_W-1:0] rp_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic                 do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  // Room for a full group of results, ignoring a pop in this cycle
  assign room       = (cnt_r <= RES_CNT_W'(RES_DEPTH - RES_MAX));

  // Write the pushed group at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wp_r + RES_PTR_W'(i)] <= push.res[i];
      end
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + RES_PTR_W'(push.cnt);
      rp_r  <= rp_r + RES_PTR_W'(do_pop);
      cnt_r <= cnt_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (cnt_r + RES_CNT_W'(push.cnt) <= RES_CNT_W'(RES_DEPTH)))
    else $error("result group pushed without room");

endmodule

[rtl/tftpc_ctrl.sv]
// ----------------------------------------------------------------------------
// tftpc_ctrl
// Transfer control: phase, expected block, wait and attempt counters, and
// the results that one registered item causes.
// ----------------------------------------------------------------------------
module tftpc_ctrl import tftpc_pkg::*; #(
  parameter int PAYLOAD_BYTES = 512
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  input  cfg_t     cfg,
  output push_t    push
);

  localparam int LEN_W = ($clog2(PAYLOAD_BYTES + HDR_BYTES + 1) > PKT_LEN_W) ?
                         $clog2(PAYLOAD_BYTES + HDR_BYTES + 1) : PKT_LEN_W;
  localparam logic [LEN_W-1:0] PKT_MAX  = LEN_W'(PAYLOAD_BYTES + HDR_BYTES);
  localparam logic [LEN_W-1:0] PAY_FULL = LEN_W'(PAYLOAD_BYTES);

  phase_t               phase_r, phase_nxt;
  logic [BLOCK_W-1:0]   exp_r, exp_nxt;
  logic [WAIT_W-1:0]    wait_r, wait_nxt;
  logic [RETRIES_W-1:0] attempt_r, attempt_nxt;
  logic [PKT_LEN_W-1:0] held_r, held_nxt;

  logic                 is_start, is_pkt, is_tick, is_chunk;
  logic                 len_ok, data_ok, ack0_ok, ack_ok;
  logic [WAIT_W-1:0]    wait_inc, get_limit;
  logic                 get_expired, expired;
  logic [PKT_LEN_W-1:0] pay, clen_clamp;
  logic                 pay_full, held_full, retries_spent;
  logic [BLOCK_W-1:0]   exp_inc;

  function automatic res_t mk_res(action_t act, logic [BLOCK_W-1:0] blk,
                                  logic [PKT_LEN_W-1:0] len);
    res_t r;
    r.action   = act;
    r.block_no = blk;
    r.length   = len;
    r.last     = 1'b0;
    return r;
  endfunction

  // Decode the item and compare against state
  assign is_start = fire && (item.opcode == OP_START);
  assign is_pkt   = fire && (item.opcode == OP_PKT);
  assign is_tick  = fire && (item.opcode == OP_TICK);
  assign is_chunk = fire && (item.opcode == OP_CHUNK);

  assign len_ok  = (item.pkt_len >= PKT_LEN_W'(HDR_BYTES)) &&
                   (LEN_W'(item.pkt_len) <= PKT_MAX);
  assign data_ok = is_pkt && len_ok && (item.pkt_kind == KIND_DATA) &&
                   (item.pkt_block == exp_r);
  assign ack0_ok = is_pkt && len_ok && (item.pkt_kind == KIND_ACK) &&
                   (item.pkt_block == '0);
  assign ack_ok  = is_pkt && len_ok && (item.pkt_kind == KIND_ACK) &&
                   (item.pkt_block == exp_r);

  assign wait_inc    = wait_r + WAIT_W'(1);
  assign get_limit   = WAIT_W'(cfg.timeout_ticks) * WAIT_W'(cfg.max_retries);
  assign get_expired = (wait_inc >= get_limit);
  assign expired     = (wait_inc >= WAIT_W'(cfg.timeout_ticks));

  assign pay        = item.pkt_len - PKT_LEN_W'(HDR_BYTES);
  assign pay_full   = (LEN_W'(pay) == PAY_FULL);
  assign clen_clamp = (LEN_W'(item.chunk_len) > PAY_FULL) ?
                      PKT_LEN_W'(PAYLOAD_BYTES) : item.chunk_len;
  assign held_full  = (LEN_W'(held_r) == PAY_FULL);
  assign retries_spent = (attempt_r >= cfg.max_retries);
  assign exp_inc    = exp_r + BLOCK_W'(1);

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    exp_nxt     = exp_r;
    wait_nxt    = wait_r;
    attempt_nxt = attempt_r;
    held_nxt    = held_r;
    if (is_start) begin
      exp_nxt     = BLOCK_W'(1);
      wait_nxt    = '0;
      attempt_nxt = '0;
      held_nxt    = '0;
      phase_nxt   = cfg.direction ? PH_PUT_ACK0 : PH_GET_WAIT;
    end else begin
      case (phase_r)
        PH_GET_WAIT: begin
          if (data_ok) begin
            if (pay_full) begin
              exp_nxt  = exp_inc;
              wait_nxt = '0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else if (is_tick) begin
            wait_nxt = wait_inc;
            if (get_expired) phase_nxt = PH_IDLE;
          end
        end
        PH_PUT_ACK0: begin
          if (ack0_ok) begin
            exp_nxt   = BLOCK_W'(1);
            phase_nxt = PH_PUT_CHUNK;
          end else if (is_tick) begin
            wait_nxt = wait_inc;
            if (expired) phase_nxt = PH_IDLE;
          end
        end
        PH_PUT_CHUNK: begin
          if (is_chunk) begin
            held_nxt    = clen_clamp;
            attempt_nxt = RETRIES_W'(1);
            wait_nxt    = '0;
            phase_nxt   = PH_PUT_ACK;
          end
        end
        PH_PUT_ACK: begin
          if (ack_ok) begin
            if (held_full) begin
              exp_nxt   = exp_inc;
              phase_nxt = PH_PUT_CHUNK;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else if (is_tick) begin
            wait_nxt = wait_inc;
            if (expired) begin
              if (retries_spent) begin
                phase_nxt = PH_IDLE;
              end else begin
                attempt_nxt = attempt_r + RETRIES_W'(1);
                wait_nxt    = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Results of this item
  always_comb begin
    push.cnt = 2'd0;
    for (int i = 0; i < RES_MAX; i++) begin
      push.res[i] = mk_res(ACT_REQ, '0, '0);
    end
    if (is_start) begin
      push.cnt    = 2'd1;
      push.res[0] = mk_res(ACT_REQ, '0, '0);
    end else begin
      case (phase_r)
        PH_GET_WAIT: begin
          if (data_ok) begin
            push.res[0] = mk_res(ACT_ACK, exp_r, '0);
            push.res[1] = mk_res(ACT_STORE, exp_r, pay);
            push.res[2] = mk_res(ACT_DONE, exp_r, '0);
            push.cnt    = pay_full ? 2'd2 : 2'd3;
          end else if (is_tick && get_expired) begin
            push.cnt    = 2'd1;
            push.res[0] = mk_res(ACT_FAIL, exp_r, '0);
          end
        end
        PH_PUT_ACK0: begin
          if (ack0_ok) begin
            push.cnt    = 2'd1;
            push.res[0] = mk_res(ACT_NEED, BLOCK_W'(1), '0);
          end else if (is_tick && expired) begin
            push.cnt    = 2'd1;
            push.res[0] = mk_res(ACT_FAIL, '0, '0);
          end
        end
        PH_PUT_CHUNK: begin
          if (is_chunk) begin
            push.cnt    = 2'd1;
            push.res[0] = mk_res(ACT_DATA, exp_r, clen_clamp);
          end
        end
        PH_PUT_ACK: begin
          if (ack_ok) begin
            push.cnt    = 2'd1;
            push.res[0] = held_full ? mk_res(ACT_NEED, exp_inc, '0) :
                                      mk_res(ACT_DONE, exp_r, '0);
          end else if (is_tick && expired) begin
            push.cnt    = 2'd1;
            push.res[0] = retries_spent ? mk_res(ACT_FAIL, exp_r, '0) :
                                          mk_res(ACT_DATA, exp_r, held_r);
          end
        end
        default: begin
        end
      endcase
    end
    // Mark the final result of the group
    for (int i = 0; i < RES_MAX; i++) begin
      push.res[i].last = (2'(i + 1) == push.cnt);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      exp_r     <= BLOCK_W'(1);
      wait_r    <= '0;
      attempt_r <= '0;
      held_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      exp_r     <= exp_nxt;
      wait_r    <= wait_nxt;
      attempt_r <= attempt_nxt;
      held_r    <= held_nxt;
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    is_start |=> (phase_r != PH_IDLE))
    else $error("start did not open a transfer");

  a_held_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(held_r) <= PAY_FULL)
    else $error("held chunk length above payload size");

  a_attempt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PUT_ACK) |-> (attempt_r != '0))
    else $error("waiting for ack with no attempt counted");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire) |-> (push.cnt == 2'd0))
    else $error("result produced without an item");

endmodule

[rtl/tftp_client_transfer_engine.sv]
// ----------------------------------------------------------------------------
// tftp_client_transfer_engine
// Client side of a TFTP transfer: turns start, packet, tick and chunk events
// into request, ack, store, data, need-chunk, done and fail actions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries one event per transfer: start, received packet, timer
//           tick or file chunk ready.
//   out_ch  carries the actions the event causes, one to three per event, in
//           order; last marks the final action of an event. Events that cause
//           nothing produce no transfer on out_ch.
//   cfg_ch  writes direction, timeout_ticks and max_retries; always ready.
//           Write only while no event is in flight.
// Path: the first action of an event reaches out_ch once its transfer on
//   in_ch has passed the input register, then control logic into the result
//   queue; its further actions follow one per cycle while out_ch is ready.
// Throughput: one event per cycle while out_ch takes one action per cycle;
//   an event with several actions occupies out_ch for one transfer per action.
// Stall: the eight-entry result queue absorbs results; in_ch drops ready once
//   the queue cannot hold three more results and a registered event waits.
// Reset: phase idle, expected block 1, counters cleared, queue empty,
//   registers back to read direction, 100 ticks and 5 retries.
// ----------------------------------------------------------------------------
module tftp_client_transfer_engine import tftpc_pkg::*; #(
  parameter int PAYLOAD_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  tftpc_in_if.sink    in_ch,
  tftpc_out_if.source out_ch,
  tftpc_cfg_if.sink   cfg_ch
);

  cfg_t     cfg_r;
  in_item_t in_r;
  logic     in_v_r;
  logic     room;
  logic     advance;
  logic     head_valid;
  res_t     head;
  push_t    push;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction     <= DIRECTION_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.max_retries   <= RETRIES_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DIRECTION: cfg_r.direction     <= cfg_ch.data[0];
        CFG_TIMEOUT:   cfg_r.timeout_ticks <= cfg_ch.data[TIMEOUT_W-1:0];
        CFG_RETRIES:   cfg_r.max_retries   <= cfg_ch.data[RETRIES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: hold the event until the queue has room for its results
  assign advance     = in_v_r && room;
  assign in_ch.ready = !in_v_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.opcode    <= in_ch.opcode;
      in_r.pkt_len   <= in_ch.pkt_len;
      in_r.pkt_kind  <= in_ch.pkt_kind;
      in_r.pkt_block <= in_ch.pkt_block;
      in_r.chunk_len <= in_ch.chunk_len;
    end
  end

  tftpc_ctrl #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_r),
    .cfg   (cfg_r),
    .push  (push)
  );

  tftpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_ch.ready),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // Drive the result channel from the queue head
  assign out_ch.valid    = head_valid;
  assign out_ch.action   = head.action;
  assign out_ch.block_no = head.block_no;
  assign out_ch.length   = head.length;
  assign out_ch.last     = head.last;

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> advance)
    else $error("results pushed without an advancing event");

  a_wait_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !room) |=> (in_v_r && $stable(in_r)))
    else $error("registered event lost while queue full");

endmodule
